// ----- rtl/psds_pkg.sv -----
package psds_pkg;

   // Operation codes carried by req_func.
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_GET    = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Sequencer states, one-hot.
   typedef enum logic [10:0] {
      ST_IDLE    = 11'b00000000001,
      ST_FREE    = 11'b00000000010,
      ST_HEAD    = 11'b00000000100,
      ST_HCMP    = 11'b00000001000,
      ST_WALK    = 11'b00000010000,
      ST_PATCH   = 11'b00000100000,
      ST_GET     = 11'b00001000000,
      ST_GREAD   = 11'b00010000000,
      ST_RHEAD   = 11'b00100000000,
      ST_RPOP    = 11'b01000000000,
      ST_RESP    = 11'b10000000000
   } state_type;

endpackage

// ----- rtl/priority_scan_disk_scheduler.sv -----
// Priority elevator disk request scheduler.
//
// Requests enter on the req_ channel (valid/ready). req_func selects insert,
// get or remove; one item on the rsp_ channel answers every request item.
// Entries live in one synchronous memory holding tag, cylinder and next link
// for each of CAPACITY entries; list heads, directions and free bits are
// flip-flops. tie_policy is written through csr_write/csr_data.
//
// Insert into a full store answers at once; into an empty level it claims a
// free entry and writes it as the list head; otherwise it also reads the head,
// walks the target list entry by entry and, unless the new entry becomes the
// head, patches the previous link. Get scans the levels in order, remove reads
// and pops the head, and the unused code answers at once. The memory's single
// read port sets the walk rate of one entry per cycle. One item is worked at
// a time; the next item is taken the cycle after the result is taken.
//
// Reset clears all list heads, directions, active level and count, marks all
// entries free and sets tie_policy to 1; no clearing pass is needed. While the
// receiver holds rsp_ready low, the result waits in the output register and
// req_ready stays low.
module priority_scan_disk_scheduler #(
   parameter int LEVELS   = 4,
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_request_tag,
   input  logic [15:0] req_cylinder,
   input  logic [7:0]  req_priority_req,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [7:0]  rsp_out_tag,
   output logic [15:0] rsp_out_cylinder,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_pending_count,
   input  logic        csr_write,
   input  logic        csr_data
);
   import psds_pkg::*;

   localparam int AW = $clog2(CAPACITY + 1);
   localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
   localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [AW-1:0] NIL = AW'(CAPACITY);

   // Entry memory word: tag, cylinder, next.
   localparam int MW = 8 + 16 + AW;
   logic [MW-1:0] mem [CAPACITY];
   logic [MW-1:0] rd_data;
   logic          mem_we;
   logic [IW-1:0] mem_waddr, mem_raddr;
   logic [MW-1:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data <= mem[mem_raddr];
   end

   wire [7:0]    rd_tag  = rd_data[MW-1 -: 8];
   wire [15:0]   rd_cyl  = rd_data[AW +: 16];
   wire [AW-1:0] rd_next = rd_data[AW-1:0];

   // Lowest free entry.
   function automatic logic [IW-1:0] first_free(logic [CAPACITY-1:0] f);
      logic [IW-1:0] idx;
      idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (f[i]) idx = IW'(i);
      end
      return idx;
   endfunction

   state_type state_ff, state_in;
   logic [AW-1:0] head_ff [2*LEVELS];
   logic [AW-1:0] head_in [2*LEVELS];
   logic [LEVELS-1:0] dir_ff, dir_in;
   logic [CAPACITY-1:0] free_ff, free_in;
   logic [LW-1:0] act_ff, act_in;
   logic [CW-1:0] count_ff, count_in;
   logic tie_ff;

   // Working registers of the current item.
   logic [7:0]    tag_ff, tag_in;
   logic [15:0]   cyl_ff, cyl_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [IW-1:0] eidx_ff, eidx_in;
   logic [AW-1:0] prev_ff, prev_in, cur_ff, cur_in;
   logic          asc_ff, asc_in;
   logic [7:0]    ptag_ff, ptag_in;
   logic [15:0]   pcyl_ff, pcyl_in;

   logic        rv_ff, rv_in;
   logic        rf_ff, rf_in;
   logic [7:0]  rt_ff, rt_in;
   logic [15:0] rc_ff, rc_in;
   logic [1:0]  rs_ff, rs_in;

   assign req_ready = state_ff == ST_IDLE && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_found = rf_ff;
   assign rsp_out_tag = rt_ff;
   assign rsp_out_cylinder = rc_ff;
   assign rsp_status = rs_ff;
   assign rsp_pending_count = 7'(count_ff);

   logic [LW:0]   slot_cur, slot_alt, slot_tgt;
   logic [AW-1:0] head_cur, head_alt, hcmp_head;
   logic [AW-1:0] rd_link;
   logic [IW-1:0] free_idx;
   logic          hcmp_asc;
   logic          stop;

   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      dir_in = dir_ff;
      free_in = free_ff;
      act_in = act_ff;
      count_in = count_ff;
      tag_in = tag_ff;
      cyl_in = cyl_ff;
      lvl_in = lvl_ff;
      eidx_in = eidx_ff;
      prev_in = prev_ff;
      cur_in = cur_ff;
      asc_in = asc_ff;
      ptag_in = ptag_ff;
      pcyl_in = pcyl_ff;
      rv_in = rv_ff && !rsp_ready;
      rf_in = rf_ff;
      rt_in = rt_ff;
      rc_in = rc_ff;
      rs_in = rs_ff;
      mem_we = 1'b0;
      mem_waddr = eidx_ff;
      mem_wdata = {tag_ff, cyl_ff, NIL};
      mem_raddr = cur_ff[IW-1:0];
      slot_cur = {lvl_ff, dir_ff[lvl_ff]};
      slot_alt = {lvl_ff, !dir_ff[lvl_ff]};
      slot_tgt = {lvl_ff, asc_ff};
      head_cur = head_ff[slot_cur];
      head_alt = head_ff[slot_alt];
      rd_link = (rd_next >= NIL) ? NIL : rd_next;
      free_idx = first_free(free_ff);
      hcmp_asc = (cyl_ff == rd_cyl) ? (dir_ff[lvl_ff] == tie_ff) : (cyl_ff > rd_cyl);
      hcmp_head = head_ff[{lvl_ff, hcmp_asc}];
      stop = asc_ff ? (cyl_ff < rd_cyl) : (cyl_ff > rd_cyl);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               tag_in = req_request_tag;
               cyl_in = req_cylinder;
               lvl_in = (req_priority_req >= 8'(LEVELS)) ? LW'(LEVELS - 1)
                                                          : LW'(req_priority_req);
               rf_in = 1'b0;
               rt_in = '0;
               rc_in = '0;
               rs_in = STATUS_OK;
               unique case (req_func)
                  FUNC_INSERT: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        rs_in = STATUS_FULL;
                        state_in = ST_RESP;
                     end else begin
                        state_in = ST_FREE;
                     end
                  end
                  FUNC_GET: begin
                     lvl_in = '0;
                     state_in = ST_GET;
                  end
                  FUNC_REMOVE: begin
                     lvl_in = act_ff;
                     state_in = ST_RHEAD;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         // Claim the lowest free entry; flip the direction if its list is empty.
         ST_FREE: begin
            eidx_in = free_idx;
            free_in[free_idx] = 1'b0;
            if (head_cur == NIL) begin
               dir_in[lvl_ff] = !dir_ff[lvl_ff];
            end
            state_in = ST_HEAD;
         end
         // Empty level: the new entry is the only one. Otherwise read the head.
         ST_HEAD: begin
            if (head_cur == NIL) begin
               head_in[slot_cur] = AW'(eidx_ff);
               mem_we = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = ST_RESP;
            end else begin
               mem_raddr = head_cur[IW-1:0];
               state_in = ST_HCMP;
            end
         end
         // Pick the target list from the head's cylinder and start the walk.
         ST_HCMP: begin
            asc_in = hcmp_asc;
            prev_in = NIL;
            if (hcmp_head == NIL) begin
               head_in[{lvl_ff, hcmp_asc}] = AW'(eidx_ff);
               mem_we = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = ST_RESP;
            end else begin
               cur_in = hcmp_head;
               mem_raddr = hcmp_head[IW-1:0];
               state_in = ST_WALK;
            end
         end
         // Walk: the data of cur_ff is valid in rd_data unless cur_ff is null.
         ST_WALK: begin
            if (cur_ff == NIL || stop) begin
               mem_we = 1'b1;
               mem_wdata = {tag_ff, cyl_ff, cur_ff};
               if (prev_ff == NIL) begin
                  head_in[slot_tgt] = AW'(eidx_ff);
                  count_in = count_ff + CW'(1);
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_PATCH;
               end
            end else begin
               // Remember this entry's contents so its link can be rewritten.
               ptag_in = rd_tag;
               pcyl_in = rd_cyl;
               prev_in = cur_ff;
               cur_in = rd_link;
               mem_raddr = rd_link[IW-1:0];
            end
         end
         // Point the previous entry at the new one.
         ST_PATCH: begin
            mem_we = 1'b1;
            mem_waddr = prev_ff[IW-1:0];
            mem_wdata = {ptag_ff, pcyl_ff, AW'(eidx_ff)};
            count_in = count_ff + CW'(1);
            state_in = ST_RESP;
         end
         // Scan one level per cycle, flipping the direction of an empty list.
         ST_GET: begin
            act_in = lvl_ff;
            if (head_cur != NIL) begin
               mem_raddr = head_cur[IW-1:0];
               state_in = ST_GREAD;
            end else begin
               dir_in[lvl_ff] = !dir_ff[lvl_ff];
               if (head_alt != NIL) begin
                  mem_raddr = head_alt[IW-1:0];
                  state_in = ST_GREAD;
               end else if (lvl_ff == LW'(LEVELS - 1)) begin
                  state_in = ST_RESP;
               end else begin
                  lvl_in = lvl_ff + LW'(1);
               end
            end
         end
         ST_GREAD: begin
            rf_in = 1'b1;
            rt_in = rd_tag;
            rc_in = rd_cyl;
            state_in = ST_RESP;
         end
         // Remove: read the head to learn its link.
         ST_RHEAD: begin
            if (head_cur == NIL) begin
               rs_in = STATUS_EMPTY;
               state_in = ST_RESP;
            end else begin
               mem_raddr = head_cur[IW-1:0];
               cur_in = head_cur;
               state_in = ST_RPOP;
            end
         end
         // Pop the head and release its entry.
         ST_RPOP: begin
            head_in[slot_cur] = rd_link;
            free_in[cur_ff[IW-1:0]] = 1'b1;
            if (count_ff != '0) count_in = count_ff - CW'(1);
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rv_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < 2*LEVELS; i++) head_ff[i] <= NIL;
         dir_ff <= '0;
         free_ff <= '1;
         act_ff <= '0;
         count_ff <= '0;
         tie_ff <= 1'b1;
         rv_ff <= 1'b0;
         rf_ff <= 1'b0;
         rt_ff <= '0;
         rc_ff <= '0;
         rs_ff <= STATUS_OK;
         tag_ff <= '0;
         cyl_ff <= '0;
         lvl_ff <= '0;
         eidx_ff <= '0;
         prev_ff <= NIL;
         cur_ff <= NIL;
         asc_ff <= 1'b0;
         ptag_ff <= '0;
         pcyl_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         dir_ff <= dir_in;
         free_ff <= free_in;
         act_ff <= act_in;
         count_ff <= count_in;
         if (csr_write) tie_ff <= csr_data;
         rv_ff <= rv_in;
         rf_ff <= rf_in;
         rt_ff <= rt_in;
         rc_ff <= rc_in;
         rs_ff <= rs_in;
         tag_ff <= tag_in;
         cyl_ff <= cyl_in;
         lvl_ff <= lvl_in;
         eidx_ff <= eidx_in;
         prev_ff <= prev_in;
         cur_ff <= cur_in;
         asc_ff <= asc_in;
         ptag_ff <= ptag_in;
         pcyl_ff <= pcyl_in;
      end
   end

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("held count above capacity");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("request taken while result pending");
   a_resp_once: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == STATUS_OK)
      else $error("found with error status");
endmodule
